// ===== src/bia_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bia_pkg: shared types and constants of the bitmap id allocator
// Map geometry, register indexes, result codes, controller states and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package bia_pkg;

  localparam int MAX_IDS   = 8192;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAX_IDS / WORD_BITS;
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(MAX_IDS);
  localparam int CNT_W     = 14;
  localparam int ID_W      = 16;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = 1'd1;

  localparam logic [ID_W-1:0]  ID_BASE_RESET  = 16'd300;
  localparam logic [CNT_W-1:0] ID_COUNT_RESET = 14'd4701;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REL_RD,
    S_REL_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic rel_read;
    logic rel_write;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rel_bad;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/bia_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bia_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/bia_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bia_ctrl: allocator controller
// Sequences one request at a time: word scan for allocate, read then write
// for release (read only if out of range), then loads the output register.
// ---------------------------------------------------------------------------
module bia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          action,
  output logic               in_stall,
  input  wire bia_pkg::sts_t sts,
  output bia_pkg::cmd_t      cmd
);
  import bia_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = action ? S_REL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_REL_RD: begin
        state_next = sts.rel_bad ? S_DONE : S_REL_WR;
      end
      S_REL_WR: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_REL_RD: begin
        cmd.rel_read = 1'b1;
      end
      S_REL_WR: begin
        cmd.rel_write = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/bia_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bia_dp: allocator datapath
// Configuration registers, managed count, bitmap RAM with per-word valid
// bits, scan pipeline with lowest-free-bit encoder, and the output register.
// ---------------------------------------------------------------------------
module bia_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bia_pkg::ID_W-1:0]      cfg_data,
  input  wire logic [bia_pkg::ID_W-1:0]      release_id,
  input  wire bia_pkg::cmd_t                 cmd,
  output bia_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [bia_pkg::STAT_W-1:0]    status,
  output logic      [bia_pkg::ID_W-1:0]      granted_id
);
  import bia_pkg::*;

  logic [ID_W-1:0]      id_base;
  logic [CNT_W-1:0]     id_count;
  logic [ID_W:0]        room;
  logic [CNT_W-1:0]     count_cap;
  logic [CNT_W-1:0]     managed;

  logic [ID_W-1:0]      rel_id;
  logic [ID_W-1:0]      rel_diff;
  logic [WADDR_W-1:0]   rel_word;
  logic [BIT_W-1:0]     rel_bit;
  logic                 rel_bad;

  logic [WADDR_W-1:0]   rd_w;
  logic [WADDR_W-1:0]   chk_w;
  logic                 chk_live;
  logic [MAP_WORDS-1:0] word_valid;
  logic                 rd_valid;

  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] chk_word;
  logic [WORD_BITS-1:0] rel_word_data;
  logic [IDX_W-1:0]     first;
  logic [CNT_W-1:0]     span;
  logic                 in_span;
  logic [WORD_BITS-1:0] span_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_hot;
  logic [BIT_W-1:0]     low_bit;
  logic                 hit;
  logic                 scan_hit;
  logic                 scan_end;
  logic                 scan_done;
  logic                 out_free;

  logic [STAT_W-1:0]    res_status;
  logic [ID_W-1:0]      res_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base  <= ID_BASE_RESET;
      id_count <= ID_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_BASE:  id_base  <= cfg_data;
        CFG_ID_COUNT: id_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    room      = (ID_W+1)'(1 << ID_W) - {1'b0, id_base};
    count_cap = (id_count > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : id_count;
    managed   = ({{(ID_W+1-CNT_W){1'b0}}, count_cap} > room) ? room[CNT_W-1:0] : count_cap;
  end

  always_comb begin
    rel_diff = rel_id - id_base;
    rel_word = rel_diff[IDX_W-1:BIT_W];
    rel_bit  = rel_diff[BIT_W-1:0];
    rel_bad  = (rel_id < id_base) ||
               (rel_diff >= {{(ID_W-CNT_W){1'b0}}, managed});
  end

  always_comb begin
    chk_word      = rd_valid ? ram_rdata : '0;
    rel_word_data = rd_valid ? ram_rdata : '0;
    first         = {chk_w, {BIT_W{1'b0}}};
    in_span       = {{(CNT_W-IDX_W){1'b0}}, first} < managed;
    span          = managed - {{(CNT_W-IDX_W){1'b0}}, first};
    span_mask     = (span >= CNT_W'(WORD_BITS)) ? '1 : ~({WORD_BITS{1'b1}} << span[BIT_W-1:0]);
    free_bits     = ~chk_word & span_mask;
    low_hot       = free_bits & (~free_bits + WORD_BITS'(1));
    low_bit       = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      low_bit = low_bit | (low_hot[i] ? BIT_W'(i) : '0);
    end
    hit       = in_span && (free_bits != '0);
    scan_hit  = cmd.scan_step && chk_live && hit;
    scan_end  = cmd.scan_step && chk_live && !hit &&
                (!in_span || (chk_w == WADDR_W'(MAP_WORDS - 1)));
    scan_done = scan_hit || scan_end;
  end

  always_comb begin
    ram_raddr = cmd.rel_read ? rel_word : rd_w;
    ram_we    = scan_hit || cmd.rel_write;
    ram_waddr = cmd.rel_write ? rel_word : chk_w;
    ram_wdata = cmd.rel_write ? (rel_word_data & ~(WORD_BITS'(1) << rel_bit))
                              : (chk_word | low_hot);
  end

  bia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (ram_we) begin
      word_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= word_valid[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_live <= 1'b0;
      rd_w     <= '0;
    end else if (cmd.capture) begin
      chk_live <= 1'b0;
      rd_w     <= '0;
    end else if (cmd.scan_step) begin
      chk_live <= 1'b1;
      rd_w     <= rd_w + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rel_id <= release_id;
    end
    if (cmd.scan_step) begin
      chk_w <= rd_w;
    end
    if (scan_hit) begin
      res_status <= STAT_OK;
      res_id     <= id_base + {{(ID_W-IDX_W){1'b0}}, chk_w, low_bit};
    end else if (scan_end) begin
      res_status <= STAT_FULL;
      res_id     <= '0;
    end else if (cmd.rel_read && rel_bad) begin
      res_status <= STAT_RANGE;
      res_id     <= '0;
    end else if (cmd.rel_write) begin
      res_status <= STAT_OK;
      res_id     <= '0;
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign sts = '{scan_done: scan_done, rel_bad: rel_bad, out_free: out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= res_status;
      granted_id <= res_id;
    end
  end

endmodule
`default_nettype wire

// ===== src/bitmap_id_allocator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_id_allocator: lowest-free identifier allocator over a word bitmap
// Input word: action (0 allocate, 1 release) and release_id, taken on
// in_valid high with in_stall low. Output word: status and granted_id, one
// per input word, held in an output register until out_stall is low.
// One request is in flight at a time; in_stall stays low only while idle,
// also while a finished result waits in the output register.
// Allocate: the scan reads w bitmap words, where w is the number of
// bitmap words read before a free bit or the end of the managed range,
// at most 256 words, one RAM read per cycle. Release: one read and one
// write of the word; the write is skipped for an id out of range.
// A stalled receiver holds the finished result in the datapath result
// register, with the controller waiting, until the output register frees.
// Reset: the map reads all free at once (per-word valid bits), id_base
// returns to 300 and id_count to 4701. Write configuration through
// cfg_we/cfg_index/cfg_data only while idle.
// ---------------------------------------------------------------------------
module bitmap_id_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bia_pkg::ID_W-1:0]      cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [bia_pkg::ID_W-1:0]      release_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [bia_pkg::STAT_W-1:0]    status,
  output logic      [bia_pkg::ID_W-1:0]      granted_id
);
  import bia_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bia_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .action  (action),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bia_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .release_id(release_id),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .granted_id(granted_id)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not make the block busy");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten while held");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_OK || status == STAT_FULL || status == STAT_RANGE))
    else $error("undefined status code");

  a_zero_id_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> granted_id == '0)
    else $error("nonzero granted_id on failed request");

  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(cmd.scan_step || cmd.rel_read || cmd.rel_write))
    else $error("datapath work while idle");

endmodule
`default_nettype wire
